@@ design/assert_macros.svh @@
// Assertion macros shared by the fan triangulation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define FTFN_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define FTFN_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FTFN_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ftfn_pkg.sv @@
// Shared types, widths and state codes for the fan triangulation block.
package ftfn_pkg;

    localparam int COORD_BITS       = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int COLOR_BITS       = 32;
    localparam int NORMAL_BITS      = 16;
    localparam int KEEP_BITS        = 30;

    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int MUL_W   = (EDGE_W > KEEP_BITS + 1) ? EDGE_W : KEEP_BITS + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CROSS_W = 2 * EDGE_W + 1;
    localparam int SQ_W    = 2 * KEEP_BITS + 2;
    localparam int LEN_W   = KEEP_BITS + 1;
    localparam int NUM_W   = KEEP_BITS + NORMAL_FRAC_BITS + 2;
    localparam int Q_W     = NORMAL_FRAC_BITS + 1;
    localparam int NX_W    = Q_W + NORMAL_BITS;
    localparam int CNT_W   = $clog2(KEEP_BITS + NORMAL_FRAC_BITS + 2);

    localparam int IN_RAW  = 3 * COORD_BITS + COLOR_BITS;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 3 * COORD_BITS + 3 * NORMAL_BITS + COLOR_BITS;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0]        color_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    // One fan triangle handed from front to back.
    typedef struct packed {
        vec_t   apex;
        vec_t   prev;
        vec_t   cur;
        color_t apex_color;
        color_t prev_color;
        color_t cur_color;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ABS,
        ST_NORM,
        ST_SQR,
        ST_SQRT,
        ST_DIVLD,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        BEAT_APEX = 2'd0,
        BEAT_PREV = 2'd1,
        BEAT_CUR  = 2'd2
    } beat_t;

endpackage

@@ design/ftfn_front.sv @@
// Front end: takes vertices, tracks the fan apex and previous vertex, queues triangles.
module ftfn_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_start,
    input  ftfn_pkg::vec_t        in_pos,
    input  ftfn_pkg::color_t      in_color,
    input  ftfn_pkg::queue_status_t q_status,
    output logic                  push,
    output ftfn_pkg::job_t        push_job
);
    import ftfn_pkg::*;

    vec_t        apex_reg, apex_next;
    vec_t        prev_reg, prev_next;
    color_t      apex_color_reg, apex_color_next;
    color_t      prev_color_reg, prev_color_next;
    logic [1:0]  seen_reg, seen_next;
    logic        accept;
    logic        is_apex;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_apex  = in_start || (seen_reg == 2'd0);

    always_comb
    begin
        apex_next       = apex_reg;
        prev_next       = prev_reg;
        apex_color_next = apex_color_reg;
        prev_color_next = prev_color_reg;
        seen_next       = seen_reg;
        push            = 1'b0;
        if (accept)
        begin
            if (is_apex)
            begin
                apex_next       = in_pos;
                apex_color_next = in_color;
                seen_next       = 2'd1;
            end
            else
            begin
                push            = (seen_reg == 2'd2);
                prev_next       = in_pos;
                prev_color_next = in_color;
                seen_next       = 2'd2;
            end
        end
    end

    always_comb
    begin
        push_job.apex       = apex_reg;
        push_job.prev       = prev_reg;
        push_job.cur        = in_pos;
        push_job.apex_color = apex_color_reg;
        push_job.prev_color = prev_color_reg;
        push_job.cur_color  = in_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apex_reg       <= '0;
            prev_reg       <= '0;
            apex_color_reg <= '0;
            prev_color_reg <= '0;
            seen_reg       <= 2'd0;
        end
        else
        begin
            apex_reg       <= apex_next;
            prev_reg       <= prev_next;
            apex_color_reg <= apex_color_next;
            prev_color_reg <= prev_color_next;
            seen_reg       <= seen_next;
        end
    end

endmodule

@@ design/ftfn_queue.sv @@
// Two-entry triangle queue between front and back.
module ftfn_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ftfn_pkg::job_t          push_job,
    input  logic                    pop,
    output ftfn_pkg::job_t          head_job,
    output ftfn_pkg::queue_status_t status
);
    import ftfn_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head_job     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/ftfn_back.sv @@
// Back end: face normal sequencer (shared multiplier, root, divider) and vertex emitter.
`include "assert_macros.svh"

module ftfn_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ftfn_pkg::queue_status_t q_status,
    input  ftfn_pkg::job_t          head_job,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ftfn_pkg::OUT_W-1:0] out_data,
    output logic                    out_last
);
    import ftfn_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;

    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e1_next [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [EDGE_W-1:0]  e2_next [3];
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [CROSS_W-1:0] cross_reg [3];
    logic signed [CROSS_W-1:0] cross_next [3];
    logic                      neg_reg [3];
    logic                      neg_next [3];
    logic [CROSS_W-1:0]        mag_reg [3];
    logic [CROSS_W-1:0]        mag_next [3];
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [SQ_W-1:0]           rv_reg, rv_next;
    logic [SQ_W-1:0]           root_reg, root_next;
    logic [SQ_W-1:0]           rbit_reg, rbit_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          div_reg, div_next;
    logic [Q_W-1:0]            quo_reg, quo_next;
    logic [1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    beat_t                     beat_reg, beat_next;
    logic [NORMAL_BITS-1:0]    nrm_reg [3];
    logic [NORMAL_BITS-1:0]    nrm_next [3];

    logic signed [MUL_W-1:0]   op_a, op_b;
    logic [2:0]                k;
    logic [SQ_W:0]             rtry;
    logic [NX_W-1:0]           qx, nfull;
    logic                      big, all_zero;
    vec_t                      sel_pos;
    color_t                    sel_color;

    assign k        = cnt_reg[2:0] - 3'd1;
    assign big      = ((mag_reg[0] | mag_reg[1] | mag_reg[2]) >> KEEP_BITS) != '0;
    assign all_zero = (mag_reg[0] | mag_reg[1] | mag_reg[2]) == '0;
    assign rtry     = {1'b0, root_reg} + {1'b0, rbit_reg};

    // Operand select for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == ST_MUL)
        begin
            case (cnt_reg[2:0])
                3'd0:    begin op_a = MUL_W'(e1_reg[1]); op_b = MUL_W'(e2_reg[2]); end
                3'd1:    begin op_a = MUL_W'(e1_reg[2]); op_b = MUL_W'(e2_reg[1]); end
                3'd2:    begin op_a = MUL_W'(e1_reg[2]); op_b = MUL_W'(e2_reg[0]); end
                3'd3:    begin op_a = MUL_W'(e1_reg[0]); op_b = MUL_W'(e2_reg[2]); end
                3'd4:    begin op_a = MUL_W'(e1_reg[0]); op_b = MUL_W'(e2_reg[1]); end
                3'd5:    begin op_a = MUL_W'(e1_reg[1]); op_b = MUL_W'(e2_reg[0]); end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end
        else
        begin
            case (cnt_reg[1:0])
                2'd0:    begin op_a = $signed(MUL_W'(mag_reg[0][KEEP_BITS-1:0])); end
                2'd1:    begin op_a = $signed(MUL_W'(mag_reg[1][KEEP_BITS-1:0])); end
                2'd2:    begin op_a = $signed(MUL_W'(mag_reg[2][KEEP_BITS-1:0])); end
                default: begin op_a = '0; end
            endcase
            op_b = op_a;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (!q_status.empty) state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == CNT_W'(6)) state_next = ST_ABS;
            ST_ABS:   state_next = ST_NORM;
            ST_NORM:
            begin
                if (!big)
                begin
                    state_next = all_zero ? ST_EMIT : ST_SQR;
                end
            end
            ST_SQR:   if (cnt_reg == CNT_W'(3)) state_next = ST_SQRT;
            ST_SQRT:  if (cnt_reg == CNT_W'(KEEP_BITS)) state_next = ST_DIVLD;
            ST_DIVLD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = (idx_reg == 2'd2) ? ST_EMIT : ST_DIVLD;
                end
            end
            ST_EMIT:  if (out_ready && beat_reg == BEAT_CUR) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        pop       = (state_reg == ST_IDLE) && !q_status.empty;
        out_valid = (state_reg == ST_EMIT);
        out_last  = (beat_reg == BEAT_CUR);
        case (beat_reg)
            BEAT_APEX: begin sel_pos = job_reg.apex; sel_color = job_reg.apex_color; end
            BEAT_PREV: begin sel_pos = job_reg.prev; sel_color = job_reg.prev_color; end
            BEAT_CUR:  begin sel_pos = job_reg.cur;  sel_color = job_reg.cur_color;  end
            default:   begin sel_pos = job_reg.cur;  sel_color = job_reg.cur_color;  end
        endcase
        out_data = OUT_W'({sel_color, nrm_reg[2], nrm_reg[1], nrm_reg[0],
                           sel_pos.z, sel_pos.y, sel_pos.x});
    end

    // Datapath
    always_comb
    begin
        job_next  = job_reg;
        e1_next   = e1_reg;
        e2_next   = e2_reg;
        prod_next = op_a * op_b;
        cross_next = cross_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        sq_next   = sq_reg;
        rv_next   = rv_reg;
        root_next = root_reg;
        rbit_next = rbit_reg;
        len_next  = len_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg + CNT_W'(1);
        beat_next = beat_reg;
        nrm_next  = nrm_reg;
        qx        = '0;
        nfull     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next   = '0;
                job_next   = head_job;
                e1_next[0] = EDGE_W'(head_job.prev.x) - EDGE_W'(head_job.apex.x);
                e1_next[1] = EDGE_W'(head_job.prev.y) - EDGE_W'(head_job.apex.y);
                e1_next[2] = EDGE_W'(head_job.prev.z) - EDGE_W'(head_job.apex.z);
                e2_next[0] = EDGE_W'(head_job.cur.x) - EDGE_W'(head_job.apex.x);
                e2_next[1] = EDGE_W'(head_job.cur.y) - EDGE_W'(head_job.apex.y);
                e2_next[2] = EDGE_W'(head_job.cur.z) - EDGE_W'(head_job.apex.z);
                for (int i = 0; i < 3; i++)
                begin
                    cross_next[i] = '0;
                end
            end
            ST_MUL:
            begin
                // product of step k lands in the next cycle
                if (cnt_reg != '0)
                begin
                    if (k[0])
                        cross_next[k[2:1]] = cross_reg[k[2:1]] - CROSS_W'(prod_reg);
                    else
                        cross_next[k[2:1]] = cross_reg[k[2:1]] + CROSS_W'(prod_reg);
                end
            end
            ST_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = cross_reg[i][CROSS_W-1];
                    mag_next[i] = cross_reg[i][CROSS_W-1] ? CROSS_W'(-cross_reg[i])
                                                          : CROSS_W'(cross_reg[i]);
                end
            end
            ST_NORM:
            begin
                cnt_next = '0;
                sq_next  = '0;
                if (big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (all_zero)
                begin
                    beat_next = BEAT_APEX;
                    for (int i = 0; i < 3; i++)
                    begin
                        nrm_next[i] = '0;
                    end
                end
            end
            ST_SQR:
            begin
                if (cnt_reg != '0)
                begin
                    sq_next = sq_reg + SQ_W'(prod_reg);
                end
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next  = '0;
                    rv_next   = sq_reg + SQ_W'(prod_reg);
                    root_next = '0;
                    rbit_next = SQ_W'(1) << (2 * KEEP_BITS);
                end
            end
            ST_SQRT:
            begin
                if ({1'b0, rv_reg} >= rtry)
                begin
                    rv_next   = rv_reg - rtry[SQ_W-1:0];
                    root_next = (root_reg >> 1) + rbit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                len_next  = root_next[LEN_W-1:0];
                idx_next  = 2'd0;
            end
            ST_DIVLD:
            begin
                cnt_next = '0;
                quo_next = '0;
                rem_next = (NUM_W'(mag_reg[idx_reg][KEEP_BITS-1:0]) << (NORMAL_FRAC_BITS + 1))
                           + NUM_W'(len_reg);
                div_next = NUM_W'({len_reg, 1'b0}) << NORMAL_FRAC_BITS;
            end
            ST_DIV:
            begin
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                    quo_next = {quo_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[Q_W-2:0], 1'b0};
                end
                div_next = div_reg >> 1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    qx    = NX_W'(quo_next);
                    nfull = neg_reg[idx_reg] ? -qx : qx;
                    nrm_next[idx_reg] = nfull[NORMAL_BITS-1:0];
                    idx_next  = idx_reg + 2'd1;
                    beat_next = BEAT_APEX;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    case (beat_reg)
                        BEAT_APEX: beat_next = BEAT_PREV;
                        BEAT_PREV: beat_next = BEAT_CUR;
                        default:   beat_next = BEAT_APEX;
                    endcase
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        prod_reg  <= prod_next;
        cross_reg <= cross_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        sq_reg    <= sq_next;
        rv_reg    <= rv_next;
        root_reg  <= root_next;
        rbit_reg  <= rbit_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        idx_reg   <= idx_next;
        nrm_reg   <= nrm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            beat_reg  <= BEAT_APEX;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            beat_reg  <= beat_next;
        end
    end

    `FTFN_ASSERT_NXT(a_idle_after_last, out_valid && out_ready && out_last, !out_valid, "valid after last beat")
    `FTFN_ASSERT_IMP(a_mag_fits, state_reg == ST_SQR, !big, "magnitude not normalized before squaring")
    `FTFN_ASSERT_IMP(a_len_nonzero, state_reg == ST_DIV, len_reg != '0, "divide by zero length")

endmodule

@@ design/fan_triangulate_flat_normals.sv @@
// Fan triangulation with flat face normals. Vertices arrive one beat each on s_axis, tuser[0]
// marking the first vertex of a polygon; from the third vertex on, each vertex yields one
// triangle as three m_axis beats (apex, previous, current), tlast on the third, all carrying
// the unit face normal in Q2.14. The front end takes a vertex per cycle while the two-entry
// triangle queue has room. The back end works one triangle at a time: a load, the cross
// product on a shared multiplier, an abs step, normalization, squaring, 31 square-root
// steps, a divide per normal component and 3 output beats. It pops no new triangle
// until the last beat of the current one is taken; a zero cross product skips the root
// and divider loops.
module fan_triangulate_flat_normals (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ftfn_pkg::IN_W-1:0]     s_axis_tdata,  // position_x, position_y, position_z, vertex_color
    input  logic [0:0]                    s_axis_tuser,  // starts_polygon
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ftfn_pkg::OUT_W-1:0]    m_axis_tdata,  // out_position_x/y/z, normal_x/y/z, out_color
    output logic                          m_axis_tlast   // last_of_triangle
);
    import ftfn_pkg::*;

    vec_t          in_pos;
    color_t        in_color;
    queue_status_t q_status;
    logic          push, pop;
    job_t          push_job, head_job;

    assign in_pos.x = s_axis_tdata[COORD_BITS-1:0];
    assign in_pos.y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_pos.z = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_color = s_axis_tdata[3*COORD_BITS+COLOR_BITS-1:3*COORD_BITS];

    ftfn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_start (s_axis_tuser[0]),
        .in_pos   (in_pos),
        .in_color (in_color),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    ftfn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    ftfn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
